// File: hw/rtl/tkec_pkg.sv
// Package for the touch key event controller: result record, batch record,
// input and result kind codes, chip command bytes and the mode byte function.
// Used by tkec_ctrl, tkec_obuf and touch_key_event_controller_unit.
package tkec_pkg;

  // Largest number of results one input item can cause.
  localparam int MAX_RES     = 4;
  localparam int MAX_KEYS    = 4;
  localparam int RES_IDX_W   = $clog2(MAX_RES);
  localparam int RES_CNT_W   = $clog2(MAX_RES + 1);

  // Input item kinds.
  localparam logic [1:0] KIND_STATUS   = 2'd0;
  localparam logic [1:0] KIND_KEY_EN   = 2'd1;
  localparam logic [1:0] KIND_PROX_EN  = 2'd2;
  localparam logic [1:0] KIND_CHIP_RST = 2'd3;

  // Result kinds.
  localparam logic [2:0] RES_RELEASE = 3'd0;
  localparam logic [2:0] RES_PRESS   = 3'd1;
  localparam logic [2:0] RES_WRITE   = 3'd2;
  localparam logic [2:0] RES_RD_CLR  = 3'd3;
  localparam logic [2:0] RES_REJECT  = 3'd4;

  // Chip command bytes.
  localparam logic [7:0] CMD_KEY_BASE  = 8'h30;
  localparam logic [7:0] CMD_KEY_PROX  = 8'h31;
  localparam logic [7:0] CMD_KEY_ALL   = 8'h3F;
  localparam logic [7:0] CMD_CHIP_RST  = 8'h20;
  localparam logic [7:0] MODE_OFF      = 8'h00;
  localparam logic [7:0] MODE_PROX     = 8'h05;
  localparam logic [7:0] MODE_KEYS     = 8'h02;

  // Upper status nibble that reports finished calibration.
  localparam logic [3:0] CAL_DONE_NIB  = 4'h4;
  localparam int         CAL_BIT       = 7;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [1:0] key_number;
    logic [7:0] write_byte;
  } res_t;

  // All results of one input item, in order, with their count.
  typedef struct packed {
    res_t [MAX_RES-1:0]   item;
    logic [RES_CNT_W-1:0] count;
  } batch_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [1:0] key, logic [7:0] wbyte);
    res_t r;
    r.result_kind = kind;
    r.key_number  = key;
    r.write_byte  = wbyte;
    return r;
  endfunction

  // Mode byte that follows a key byte, from the enable mask.
  function automatic logic [7:0] mode_byte(logic [MAX_KEYS-1:0] mask);
    logic [7:0] m;
    if (mask == '0) begin
      m = MODE_OFF;
    end else if (mask == MAX_KEYS'(1)) begin
      m = MODE_PROX;
    end else begin
      m = MODE_KEYS;
    end
    return m;
  endfunction

endpackage

// File: hw/rtl/tkec_ctrl.sv
// Key state registers and the single-pass evaluation of one input item into
// its list of results. Depends on tkec_pkg.
module tkec_ctrl #(
  parameter int NUM_KEYS = tkec_pkg::MAX_KEYS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [1:0]        kind,
  input  logic [7:0]        status,
  input  logic              read_ok,
  input  logic [1:0]        key_index,
  input  logic              enable,
  input  logic              batch_last,
  output tkec_pkg::batch_t  batch
);

  logic [NUM_KEYS-1:0]           en_mask_r, en_mask_nxt;
  logic [NUM_KEYS-1:0]           prs_mask_r, prs_mask_nxt;
  logic                          calib_r, calib_nxt;
  logic                          rdfail_r, rdfail_nxt;

  logic [tkec_pkg::RES_CNT_W-1:0] n;
  logic [NUM_KEYS-1:0]           now_keys;
  logic [NUM_KEYS-1:0]           rel_set;
  logic [NUM_KEYS-1:0]           prs_set;
  logic [NUM_KEYS-1:0]           key_bit;
  logic [tkec_pkg::MAX_KEYS-1:0] mask_ext;
  logic [tkec_pkg::MAX_KEYS-1:0] mask_cur_ext;
  logic                          key_bad;
  logic [7:0]                    batch_byte;

  assign now_keys = status[NUM_KEYS-1:0];
  assign key_bit  = NUM_KEYS'(1) << key_index;
  assign key_bad  = (key_index == 2'd0) || ({1'b0, key_index} >= 3'(NUM_KEYS));

  // Evaluate the item: next key state and the ordered result list.
  always_comb begin
    en_mask_nxt  = en_mask_r;
    prs_mask_nxt = prs_mask_r;
    calib_nxt    = calib_r;
    rdfail_nxt   = rdfail_r;
    batch        = '0;
    n            = '0;
    rel_set      = en_mask_r & prs_mask_r;
    prs_set      = '0;
    mask_ext     = '0;
    mask_cur_ext = '0;
    mask_cur_ext[NUM_KEYS-1:0] = en_mask_r;
    batch_byte   = tkec_pkg::CMD_KEY_BASE;

    case (kind)
      tkec_pkg::KIND_STATUS: begin
        if (!read_ok || status[tkec_pkg::CAL_BIT]) begin
          // Failed read or calibration start: release every held key that is enabled.
          for (int i = 0; i < NUM_KEYS; i++) begin
            if (rel_set[i]) begin
              batch.item[n[tkec_pkg::RES_IDX_W-1:0]] =
                tkec_pkg::mk_res(tkec_pkg::RES_RELEASE, 2'(i), 8'h00);
              n = n + 1'b1;
            end
          end
          prs_mask_nxt = '0;
          if (!read_ok) begin
            rdfail_nxt = 1'b1;
          end else begin
            calib_nxt = 1'b1;
          end
        end else if (calib_r) begin
          if (status[7:4] == tkec_pkg::CAL_DONE_NIB) begin
            calib_nxt = 1'b0;
            batch.item[0] = tkec_pkg::mk_res(tkec_pkg::RES_WRITE, 2'd0,
                                             tkec_pkg::CMD_KEY_BASE | 8'(mask_cur_ext));
            batch.item[1] = tkec_pkg::mk_res(tkec_pkg::RES_WRITE, 2'd0,
                                             tkec_pkg::mode_byte(mask_cur_ext));
            n = 3'd2;
          end else begin
            // Calibration not done: all keys off, mode byte for an empty mask.
            en_mask_nxt   = '0;
            batch.item[0] = tkec_pkg::mk_res(tkec_pkg::RES_WRITE, 2'd0,
                                             tkec_pkg::mode_byte('0));
            n = 3'd1;
          end
        end else begin
          // Normal report: releases first, then presses, ascending keys.
          rel_set = ~now_keys & prs_mask_r & en_mask_r;
          prs_set = now_keys & ~prs_mask_r & en_mask_r;
          for (int i = 0; i < NUM_KEYS; i++) begin
            if (rel_set[i]) begin
              batch.item[n[tkec_pkg::RES_IDX_W-1:0]] =
                tkec_pkg::mk_res(tkec_pkg::RES_RELEASE, 2'(i), 8'h00);
              n = n + 1'b1;
            end
          end
          for (int i = 0; i < NUM_KEYS; i++) begin
            if (prs_set[i]) begin
              batch.item[n[tkec_pkg::RES_IDX_W-1:0]] =
                tkec_pkg::mk_res(tkec_pkg::RES_PRESS, 2'(i), 8'h00);
              n = n + 1'b1;
            end
          end
          prs_mask_nxt = now_keys;
        end
      end

      tkec_pkg::KIND_KEY_EN: begin
        // A pending failed read is cleared by a read first.
        if (rdfail_r) begin
          batch.item[0] = tkec_pkg::mk_res(tkec_pkg::RES_RD_CLR, 2'd0, 8'h00);
          n = 3'd1;
          if (read_ok) begin
            rdfail_nxt = 1'b0;
          end
        end
        if (key_bad) begin
          batch.item[n[tkec_pkg::RES_IDX_W-1:0]] =
            tkec_pkg::mk_res(tkec_pkg::RES_REJECT, 2'd0, 8'h00);
          n = n + 1'b1;
        end else begin
          if (enable) begin
            en_mask_nxt = en_mask_r | key_bit;
          end else begin
            if ((prs_mask_r & key_bit) != '0) begin
              batch.item[n[tkec_pkg::RES_IDX_W-1:0]] =
                tkec_pkg::mk_res(tkec_pkg::RES_RELEASE, key_index, 8'h00);
              n = n + 1'b1;
              prs_mask_nxt = prs_mask_r & ~key_bit;
            end
            en_mask_nxt = en_mask_r & ~key_bit;
          end
          if (batch_last) begin
            mask_ext[NUM_KEYS-1:0] = en_mask_nxt;
            if (enable) begin
              batch_byte = tkec_pkg::CMD_KEY_ALL;
            end else if (en_mask_nxt[0]) begin
              batch_byte = tkec_pkg::CMD_KEY_PROX;
            end else begin
              batch_byte = tkec_pkg::CMD_KEY_BASE;
            end
            batch.item[n[tkec_pkg::RES_IDX_W-1:0]] =
              tkec_pkg::mk_res(tkec_pkg::RES_WRITE, 2'd0, batch_byte);
            n = n + 1'b1;
            batch.item[n[tkec_pkg::RES_IDX_W-1:0]] =
              tkec_pkg::mk_res(tkec_pkg::RES_WRITE, 2'd0, tkec_pkg::mode_byte(mask_ext));
            n = n + 1'b1;
          end
        end
      end

      tkec_pkg::KIND_PROX_EN: begin
        en_mask_nxt[0] = enable;
        mask_ext[NUM_KEYS-1:0] = en_mask_nxt;
        batch.item[0] = tkec_pkg::mk_res(tkec_pkg::RES_WRITE, 2'd0,
                                         tkec_pkg::CMD_KEY_BASE | 8'(mask_ext));
        batch.item[1] = tkec_pkg::mk_res(tkec_pkg::RES_WRITE, 2'd0,
                                         tkec_pkg::mode_byte(mask_ext));
        n = 3'd2;
      end

      default: begin
        batch.item[0] = tkec_pkg::mk_res(tkec_pkg::RES_WRITE, 2'd0, tkec_pkg::CMD_CHIP_RST);
        n = 3'd1;
      end
    endcase

    batch.count = n;
  end

  // Key state registers, updated on each accepted input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_mask_r  <= NUM_KEYS'(1);
      prs_mask_r <= '0;
      calib_r    <= 1'b0;
      rdfail_r   <= 1'b0;
    end else if (accept) begin
      en_mask_r  <= en_mask_nxt;
      prs_mask_r <= prs_mask_nxt;
      calib_r    <= calib_nxt;
      rdfail_r   <= rdfail_nxt;
    end
  end

endmodule

// File: hw/rtl/tkec_obuf.sv
// Result register: holds the result list of one item and hands the results
// out one per cycle while out_ready is high on the output channel. Depends on tkec_pkg.
module tkec_obuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  tkec_pkg::batch_t batch,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_result_kind,
  output logic [1:0]       out_key_number,
  output logic [7:0]       out_write_byte,
  output logic             out_last
);

  tkec_pkg::batch_t                buf_r;
  logic [tkec_pkg::RES_IDX_W-1:0]  idx_r;
  logic                            valid_r;
  logic                            out_xfer;
  tkec_pkg::res_t                  cur;

  assign cur             = buf_r.item[idx_r];
  assign out_valid       = valid_r;
  assign out_result_kind = cur.result_kind;
  assign out_key_number  = cur.key_number;
  assign out_write_byte  = cur.write_byte;
  assign out_last        = ({1'b0, idx_r} == (buf_r.count - 1'b1));
  assign out_xfer        = valid_r && out_ready;

  // A new list may enter while the final result leaves.
  assign can_load = !valid_r || (out_ready && out_last);

  // Payload of the result list.
  always_ff @(posedge clk) begin
    if (load && (batch.count != '0)) begin
      buf_r <= batch;
    end
  end

  // Read pointer and valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= (batch.count != '0);
      idx_r   <= '0;
    end else if (out_xfer) begin
      if (out_last) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // A held list is never empty.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (buf_r.count != '0))
    else $error("result list held with zero count");

  // The read pointer stays inside the held list.
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ({1'b0, idx_r} < buf_r.count))
    else $error("result pointer beyond list");

  // A taken result that is not the last leaves another one showing.
  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && !out_last) |=> (valid_r && (idx_r == $past(idx_r) + 1'b1)))
    else $error("result list cut short");

endmodule

// File: hw/rtl/touch_key_event_controller_unit.sv
// Top level of the touch key event controller: input channel, key state and
// evaluation (tkec_ctrl), result register (tkec_obuf). Depends on tkec_pkg.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one request or status
//   report per transfer. Each item causes zero to four results, which leave
//   on the output channel (out_valid/out_ready), one per transfer, in order;
//   out_last marks the final result of an item.
//   Latency: the first result of an item shows in the cycle after its input
//   transfer. The item is evaluated combinationally into a result register.
//   Throughput: an item with n results occupies the output for n transfers
//   (one to four); the next item is taken in the same cycle its final result
//   is transferred, so items causing no result go at one per cycle.
//   Reset (rst_n low, synchronous): the enable mask holds the proximity key
//   only, no key is held, calibration and failed-read flags are clear, and
//   the result register is empty.
//   When the receiver stalls, the current result holds and in_ready stays
//   low until the final result of the held item is being transferred.
module touch_key_event_controller_unit #(
  parameter int NUM_KEYS = tkec_pkg::MAX_KEYS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_status,
  input  logic       in_read_ok,
  input  logic [1:0] in_key_index,
  input  logic       in_enable,
  input  logic       in_batch_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_result_kind,
  output logic [1:0] out_key_number,
  output logic [7:0] out_write_byte,
  output logic       out_last
);

  logic             in_xfer;
  tkec_pkg::batch_t batch;

  // An input transfer happens when the result register can take its list.
  assign in_xfer = in_valid && in_ready;

  tkec_ctrl #(
    .NUM_KEYS(NUM_KEYS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_xfer),
    .kind      (in_kind),
    .status    (in_status),
    .read_ok   (in_read_ok),
    .key_index (in_key_index),
    .enable    (in_enable),
    .batch_last(in_batch_last),
    .batch     (batch)
  );

  tkec_obuf u_obuf (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (in_xfer),
    .batch          (batch),
    .can_load       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_kind(out_result_kind),
    .out_key_number (out_key_number),
    .out_write_byte (out_write_byte),
    .out_last       (out_last)
  );

endmodule
